// File: sv/bfmdh_pkg.sv
// shared types and constants for the bloom filter with murmur double hashing
package bfmdh_pkg;

  localparam int KEY_W = 32;
  localparam int HW = 64;

  localparam logic [HW-1:0] HASH_SEED = 64'd4;
  localparam logic [HW-1:0] C1 = 64'h87c37b91114253d5;
  localparam logic [HW-1:0] C2 = 64'h4cf5ad432745937f;
  localparam logic [HW-1:0] F1 = 64'hff51afd7ed558ccd;
  localparam logic [HW-1:0] F2 = 64'hc4ceb9fe1a85ec53;
  localparam logic [HW-1:0] MSG_LEN = 64'd4;

  // command codes
  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // configuration register indexes
  localparam logic [0:0] REG_NUM_BITS = 1'b0;
  localparam logic [0:0] REG_NUM_HASHES = 1'b1;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 18;
  localparam logic [17:0] NUM_BITS_RST = 18'd100000;
  localparam logic [4:0] NUM_HASHES_RST = 5'd5;

  // hashed request handed from front to back
  typedef struct packed {
    logic cmd;
    logic [HW-1:0] h1;
    logic [HW-1:0] h2;
  } hreq_t;

  // back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE, ST_STEP, ST_ADV, ST_MOD, ST_PROBE, ST_READ, ST_DONE
  } bst_t;

endpackage

// File: sv/bloom_filter_murmur_double_hash_top.sv
// top level of the bloom filter with murmur3 double hashing
// One request is hashed by the front end after it is accepted and then handed to the queue,
// while the back end works on the previous one. For each probe of an add or a query the
// back end reduces the probe value modulo num_bits (clamped to 1..MAX_BITS) by a
// one-bit-per-cycle restoring remainder unit over the 64-bit probe value, which sets the
// rate. The bit store is a memory with one write port and one read port that is swept to
// zero after reset; the back end takes no request during the sweep.
module bloom_filter_murmur_double_hash_top #(
  parameter int MAX_BITS = 131072,
  parameter int MAX_HASHES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bfmdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfmdh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic command,
  input  logic signed [31:0] key,
  output logic out_valid,
  input  logic out_stall,
  output logic present
);
  import bfmdh_pkg::*;

  logic [17:0] num_bits;
  logic [4:0] num_hashes;
  hreq_t f_req, q_req;
  logic f_valid, f_stall, q_valid, q_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      num_bits <= NUM_BITS_RST;
      num_hashes <= NUM_HASHES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_BITS: num_bits <= cfg_data;
        REG_NUM_HASHES: num_hashes <= cfg_data[4:0];
        default: num_bits <= num_bits;
      endcase
    end
  end

  bfmdh_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(command), .in_key(key), .out_valid(f_valid), .out_stall(f_stall), .out_req(f_req)
  );

  bfmdh_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_stall(f_stall), .in_req(f_req),
    .out_valid(q_valid), .out_stall(q_stall), .out_req(q_req)
  );

  bfmdh_back #(.MAX_BITS(MAX_BITS), .MAX_HASHES(MAX_HASHES)) u_back (
    .clk(clk), .rst(rst), .num_bits(num_bits), .num_hashes(num_hashes),
    .in_valid(q_valid), .in_stall(q_stall), .in_req(q_req),
    .out_valid(out_valid), .out_stall(out_stall), .out_present(present)
  );
endmodule

// File: sv/bfmdh_mul.sv
// pipelined 64-bit low-half multiplier, three 32x32 partials then a sum
module bfmdh_mul (
  input  logic clk,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);
  logic [63:0] ll, lh, hl;

  // partial products
  always_ff @(posedge clk) begin
    ll <= {32'd0, a[31:0]} * {32'd0, b[31:0]};
    lh <= {32'd0, a[31:0]} * {32'd0, b[63:32]};
    hl <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
  end

  // combine
  always_ff @(posedge clk) begin
    p <= ll + {lh[31:0], 32'd0} + {hl[31:0], 32'd0};
  end
endmodule

// File: sv/bfmdh_front.sv
// front end: accepts requests and runs the murmur3 hash as a sequenced datapath
module bfmdh_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic in_cmd,
  input  logic [31:0] in_key,
  output logic out_valid,
  input  logic out_stall,
  output bfmdh_pkg::hreq_t out_req
);
  import bfmdh_pkg::*;

  // one shared pipelined multiplier, stepped by a phase counter
  logic [4:0] phase, phase_next;
  logic busy, busy_next;
  logic done, done_next;
  logic cmd;
  logic [HW-1:0] x, h1, h2;
  logic [HW-1:0] ma, mb, mp;
  logic [HW-1:0] h1_mix;

  bfmdh_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  always_comb begin
    ma = x;
    mb = C1;
    case (phase)
      5'd0: mb = C1;
      5'd3: mb = C2;
      5'd6, 5'd12: mb = F1;
      5'd9, 5'd15: mb = F2;
      default: mb = C1;
    endcase
  end

  // tail mixing of the key block into h1
  assign h1_mix = (HASH_SEED ^ mp ^ MSG_LEN) + (HASH_SEED ^ MSG_LEN);

  assign in_stall = busy || done;
  assign out_valid = done;
  assign out_req = '{cmd: cmd, h1: h1, h2: h2};

  always_comb begin
    busy_next = busy;
    done_next = done;
    phase_next = phase;
    if (in_valid && !in_stall) begin
      busy_next = 1'b1;
      phase_next = 5'd0;
    end else if (busy) begin
      phase_next = phase + 5'd1;
      if (phase == 5'd17) begin
        busy_next = 1'b0;
      end
    end
    if (busy && phase == 5'd17) done_next = 1'b1;
    if (done && !out_stall) done_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      phase <= 5'd0;
    end else begin
      busy <= busy_next;
      done <= done_next;
      phase <= phase_next;
    end
  end

  // hash datapath; each product passes the multiplier's partial and sum registers before use
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd <= in_cmd;
      x <= {32'd0, in_key};
    end else if (busy) begin
      case (phase)
        5'd2: x <= {mp[32:0], mp[63:33]};
        5'd5: begin
          h1 <= h1_mix;
          h2 <= HASH_SEED ^ MSG_LEN;
          x <= h1_mix ^ (h1_mix >> 33);
        end
        5'd6: h2 <= h2 + h1;
        5'd8: x <= mp ^ (mp >> 33);
        5'd11: begin
          h1 <= mp ^ (mp >> 33);
          x <= h2 ^ (h2 >> 33);
        end
        5'd14: x <= mp ^ (mp >> 33);
        5'd17: begin
          h1 <= h1 + (mp ^ (mp >> 33));
          h2 <= h1 + ((mp ^ (mp >> 33)) << 1);
        end
        default: x <= x;
      endcase
    end
  end
endmodule

// File: sv/bfmdh_queue.sv
// two-entry queue between the hash front end and the probe back end
module bfmdh_queue (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  bfmdh_pkg::hreq_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output bfmdh_pkg::hreq_t out_req
);
  import bfmdh_pkg::*;

  hreq_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  logic push, pop;

  assign in_stall = (cnt == 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_req = mem[rp];
  assign push = in_valid && !in_stall;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// File: sv/bfmdh_back.sv
// back end: steps the probes, reduces each mod m and updates or checks the bit store
module bfmdh_back #(
  parameter int MAX_BITS = 131072,
  parameter int MAX_HASHES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic [17:0] num_bits,
  input  logic [4:0] num_hashes,
  input  logic in_valid,
  output logic in_stall,
  input  bfmdh_pkg::hreq_t in_req,
  output logic out_valid,
  input  logic out_stall,
  output logic out_present
);
  import bfmdh_pkg::*;

  localparam int AW = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int KW = $clog2(MAX_HASHES + 1);
  localparam int MW = $clog2(MAX_BITS + 1);
  localparam int CW = $clog2(HW + 1);

  bst_t st, st_next;
  logic cmd, all_set;
  logic [HW-1:0] h1, h2, step, h;
  logic [KW-1:0] k, cnt;
  logic [MW-1:0] m;
  logic [HW-1:0] rem;
  logic [CW-1:0] bitc;
  logic [AW-1:0] idx;
  logic mem [MAX_BITS];
  logic rd;
  logic [HW-1:0] ma, mb, mp;
  logic [1:0] wait_cnt;
  logic res_valid;
  logic [MW:0] trial;
  logic clearing;
  logic [AW-1:0] clr_addr;

  bfmdh_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));
  assign ma = h2;
  assign mb = {{(HW-KW){1'b0}}, k};

  // effective register values
  logic [MW-1:0] m_eff;
  logic [KW-1:0] k_eff;
  always_comb begin
    if (num_bits == 18'd0) m_eff = MW'(1);
    else if ({14'd0, num_bits} > 32'(MAX_BITS)) m_eff = MW'(MAX_BITS);
    else m_eff = MW'(num_bits);
    if (num_hashes == 5'd0) k_eff = KW'(1);
    else if ({27'd0, num_hashes} > 32'(MAX_HASHES)) k_eff = KW'(MAX_HASHES);
    else k_eff = KW'(num_hashes);
  end

  // restoring remainder, one dividend bit per cycle
  assign trial = {rem[MW-1:0], h[HW-1-bitc[5:0]]} ;

  assign in_stall = (st != ST_IDLE) || clearing;
  assign out_valid = res_valid;

  // next state
  always_comb begin
    st_next = st;
    case (st)
      ST_IDLE: if (in_valid && !clearing) st_next = ST_STEP;
      ST_STEP: if (wait_cnt == 2'd2) st_next = ST_ADV;
      ST_ADV: st_next = ST_MOD;
      ST_MOD: if (bitc == CW'(HW - 1)) st_next = ST_PROBE;
      ST_PROBE: st_next = cmd ? ST_READ : ((cnt == k) ? ST_DONE : ST_ADV);
      ST_READ: st_next = (cnt == k) ? ST_DONE : ST_ADV;
      ST_DONE: if (!res_valid || !out_stall) st_next = ST_IDLE;
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
      res_valid <= 1'b0;
    end else begin
      st <= st_next;
      if (res_valid && !out_stall) res_valid <= 1'b0;
      if (st == ST_DONE && (!res_valid || !out_stall) && cmd == CMD_QUERY) res_valid <= 1'b1;
    end
  end

  // clearing sweep over the whole store after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(MAX_BITS - 1)) clearing <= 1'b0;
    end
  end

  // bit store
  always_ff @(posedge clk) begin
    if (clearing) mem[clr_addr] <= 1'b0;
    else if (st == ST_PROBE && cmd == CMD_ADD) mem[idx] <= 1'b1;
    rd <= mem[idx];
  end

  // datapath
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        cmd <= in_req.cmd;
        h1 <= in_req.h1;
        h2 <= in_req.h2;
        k <= k_eff;
        m <= m_eff;
        wait_cnt <= 2'd0;
        cnt <= '0;
        all_set <= 1'b1;
      end
      ST_STEP: begin
        wait_cnt <= wait_cnt + 2'd1;
        step <= mp;
        h <= h1;
      end
      ST_ADV: begin
        h <= h + step;
        cnt <= cnt + KW'(1);
        rem <= '0;
        bitc <= '0;
      end
      ST_MOD: begin
        if (trial >= {1'b0, m}) rem <= HW'(trial - {1'b0, m});
        else rem <= HW'(trial);
        bitc <= bitc + CW'(1);
        if (bitc == CW'(HW - 1)) begin
          if (trial >= {1'b0, m}) idx <= AW'(trial - {1'b0, m});
          else idx <= AW'(trial);
        end
      end
      ST_READ: if (!rd) all_set <= 1'b0;
      ST_DONE: if (!res_valid || !out_stall) out_present <= all_set;
      default: cnt <= cnt;
    endcase
  end
endmodule

// File: test/bfmdh_checker.sv
// request and result checker for the bloom filter with murmur double hashing
module bfmdh_checker #(
  parameter int MAX_BITS = 131072,
  parameter int MAX_HASHES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_we,
  input  logic [bfmdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bfmdh_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic in_valid,
  input  logic in_stall,
  input  logic command,
  input  logic signed [31:0] key,
  input  logic out_valid,
  input  logic out_stall,
  input  logic present,
  output int   errors,
  output int   pending,
  output int   results
);
  timeunit 1ns;
  timeprecision 1ps;
  import bfmdh_pkg::*;

  // shadow copy of the bit store and registers
  bit filter_shadow [MAX_BITS];
  logic [17:0] bits_reg;
  logic [4:0] hashes_reg;
  logic expected_present [$];

  assign pending = expected_present.size();

  function automatic logic [63:0] fmix(input logic [63:0] x);
    x = x ^ (x >> 33);
    x = x * F1;
    x = x ^ (x >> 33);
    x = x * F2;
    x = x ^ (x >> 33);
    return x;
  endfunction

  // hash the key, then add it to the shadow store or test its probe bits
  function automatic logic apply_key(input logic cmd, input logic [31:0] k32);
    logic [63:0] t, a, b, h, step, m, nk, idx;
    logic all_set;
    all_set = 1'b1;
    t = {32'd0, k32} * C1;
    t = {t[32:0], t[63:33]};
    t = t * C2;
    a = HASH_SEED ^ t ^ MSG_LEN;
    b = HASH_SEED ^ MSG_LEN;
    a = a + b;
    b = b + a;
    a = fmix(a);
    b = fmix(b);
    a = a + b;
    b = b + a;
    m = (bits_reg == 0) ? 64'd1 : (bits_reg > MAX_BITS) ? 64'(MAX_BITS) : 64'(bits_reg);
    nk = (hashes_reg == 0) ? 64'd1 :
         (hashes_reg > MAX_HASHES) ? 64'(MAX_HASHES) : 64'(hashes_reg);
    step = nk * b;
    h = a;
    for (int i = 0; i < nk; i++) begin
      h = h + step;
      idx = h % m;
      if (cmd == CMD_ADD) filter_shadow[idx] = 1'b1;
      else if (!filter_shadow[idx]) all_set = 1'b0;
    end
    return all_set;
  endfunction

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    logic got;
    if (rst) begin
      foreach (filter_shadow[i]) filter_shadow[i] = 1'b0;
      bits_reg = NUM_BITS_RST;
      hashes_reg = NUM_HASHES_RST;
      expected_present.delete();
      errors = 0;
      results = 0;
    end else begin
      // register writes
      if (cfg_we) begin
        if (cfg_index == REG_NUM_BITS) bits_reg = cfg_data[17:0];
        else if (cfg_index == REG_NUM_HASHES) hashes_reg = cfg_data[4:0];
      end
      // accepted request
      if (in_valid && !in_stall) begin
        got = apply_key(command, key);
        if (command == CMD_QUERY) expected_present.push_back(got);
      end
      // accepted result
      if (out_valid && !out_stall) begin
        results++;
        if (expected_present.size() == 0) report("result with no query waiting");
        else begin
          got = expected_present.pop_front();
          if (present !== got)
            report($sformatf("present %b, expected %b", present, got));
        end
      end
    end
  end
endmodule

// File: test/tb.sv
// stimulus and verdict for the bloom filter with murmur double hashing
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfmdh_pkg::*;

  localparam int WATCH_LIMIT = 600000;
  localparam int SETTLE = 6000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_ADD;
  logic signed [31:0] key = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic present;
  int errors, pending, results;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int idle_run = 0;
  int sent = 0;
  int phases = 0;
  logic [31:0] added_keys [$];

  always #10 clk = ~clk;

  bloom_filter_murmur_double_hash_top DUT (.*);

  bfmdh_checker chk (.*);

  // receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_run <= 0;
      else idle_run <= idle_run + 1;
      if (idle_run >= WATCH_LIMIT) begin
        $display("watchdog: no handshake in %0d cycles", WATCH_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // valid stays up after an accept until the next request or an idle cycle drops it
  task automatic send_request(input logic cmd, input logic [31:0] k32);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    key <= k32;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
    if (cmd == CMD_ADD && added_keys.size() < 4096) added_keys.push_back(k32);
  endtask

  // write a register once every result is in and the back end has drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input logic [17:0] nbits, input logic [17:0] nhash,
                              input int count, input int sidle, input int rstall,
                              input int hold);
    int pick;
    write_reg(REG_NUM_BITS, nbits);
    write_reg(REG_NUM_HASHES, nhash);
    send_idle_pct = sidle;
    stall_pct = rstall;
    phases++;
    if (hold > 0) hold_left = hold;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40 || added_keys.size() == 0) send_request(CMD_ADD, $urandom);
      else if (pick < 70)
        send_request(CMD_QUERY, added_keys[$urandom_range(added_keys.size() - 1)]);
      else send_request(CMD_QUERY, $urandom);
    end
  endtask

  initial begin
    int wait_cycles;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: key extremes, add then query, query of absent keys
    send_request(CMD_QUERY, 32'h0000_0000);
    send_request(CMD_ADD, 32'h0000_0000);
    send_request(CMD_QUERY, 32'h0000_0000);
    send_request(CMD_ADD, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 32'hFFFF_FFFF);
    send_request(CMD_QUERY, 32'h7FFF_FFFF);
    send_request(CMD_ADD, 32'h7FFF_FFFF);
    send_request(CMD_QUERY, 32'h7FFF_FFFF);
    send_request(CMD_ADD, 32'h8000_0000);
    send_request(CMD_QUERY, 32'h8000_0000);
    send_request(CMD_QUERY, 32'h0000_0001);
    send_request(CMD_ADD, 32'h0000_0001);
    send_request(CMD_QUERY, 32'h0000_0001);
    send_request(CMD_QUERY, 32'h5555_5555);
    send_request(CMD_QUERY, 32'hAAAA_AAAA);
    send_request(CMD_ADD, 32'hAAAA_AAAA);
    send_request(CMD_QUERY, 32'hAAAA_AAAA);
    send_request(CMD_QUERY, 32'h0000_0000);

    // random phases over register settings; store is never cleared between them
    random_phase(18'd100000, 18'd5, 400, 0, 0, 0);
    random_phase(18'd0, 18'd3, 60, 79, 0, 0);
    random_phase(18'h3FFFF, 18'd2, 300, 0, 79, 0);
    random_phase(18'd131072, 18'd0, 300, 24, 24, 0);
    random_phase(18'd64, 18'd16, 40, 0, 0, 0);
    random_phase(18'd1000, 18'h3FFFF, 40, 79, 0, 0);
    random_phase(18'd131071, 18'd8, 200, 0, 0, 3000);
    random_phase(18'd5000, 18'd4, 300, 0, 79, 0);
    random_phase(18'd100000, 18'd5, 300, 24, 24, 0);
    in_valid <= 1'b0;

    // drain
    wait_cycles = 0;
    while (pending != 0 && wait_cycles < 200000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (SETTLE) @(negedge clk);
    if (pending != 0) $display("%0d expected results never arrived", pending);

    $display("%0d requests over %0d register settings, %0d query results checked",
             sent, phases + 1, results);
    $display("extremes of bit count and probe count, clamping, long receiver hold-off");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
